// ===== sv/assert_macros.svh =====
// Assertion macros shared by the baud divider RTL.
// Needs signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ubd_pkg.sv =====
// Types, constants and prescaler tables of the UART baud divider.
// No dependencies; used by every module of the block except ubd_div_pipe.
package ubd_pkg;

   // Oscillator defaults in hertz
   localparam int INTERNAL_OSC_HZ_DEF = 8000000;
   localparam int EXTERNAL_OSC_HZ_DEF = 8000000;

   // Field and datapath widths
   localparam int PORT_W      = 2;
   localparam int BAUD_W      = 32;
   localparam int DIV_W       = 16;
   localparam int ACTUAL_W    = 23;
   localparam int BUS_W       = 27;
   localparam int CLK_W       = 28;
   localparam int NUM_W       = BAUD_W + 1;
   localparam int Q2_W        = CLK_W - 4;
   localparam int SHIFT_W     = 4;
   localparam int MULT_W      = 5;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 4;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 72;

   // Divider limits and PLL factor cap
   localparam logic [DIV_W-1:0]  DIV_MIN       = 16'd16;
   localparam logic [3:0]        PLL_CAP_CODE  = 4'd14;
   localparam logic [MULT_W-1:0] PLL_MULT_MAX  = 5'd16;
   localparam logic [MULT_W-1:0] PLL_MULT_BASE = 5'd2;
   localparam logic [PORT_W-1:0] PORT_FAST     = 2'd0;
   localparam logic [PORT_W-1:0] PORT_INVALID  = 2'd3;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_REQ = 2'd1,
      ST_RANGE   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SRC_INTERNAL = 2'd0,
      SRC_EXTERNAL = 2'd1,
      SRC_PLL      = 2'd2,
      SRC_SPARE    = 2'd3
   } src_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYSCLK_SOURCE     = 3'd0,
      CSR_PLL_MULT_CODE     = 3'd1,
      CSR_PLL_FROM_EXTERNAL = 3'd2,
      CSR_EXTERNAL_HALVED   = 3'd3,
      CSR_AHB_PRESCALE      = 3'd4,
      CSR_SLOW_PRESCALE     = 3'd5,
      CSR_FAST_PRESCALE     = 3'd6
   } csr_index_type;

   // Clock-tree settings
   typedef struct packed {
      logic [1:0] sysclk_source;
      logic [3:0] pll_mult_code;
      logic       pll_from_external;
      logic       external_halved;
      logic [3:0] ahb_prescale_code;
      logic [2:0] slow_bus_prescale_code;
      logic [2:0] fast_bus_prescale_code;
   } cfg_type;

   // Sideband through the baud division
   typedef struct packed {
      logic             bad_port;
      logic             zero_baud;
      logic             too_slow;
      logic [CLK_W-1:0] bus_clk;
   } d1_side_type;

   // Sideband through the actual-baud division
   typedef struct packed {
      status_type       status;
      logic [DIV_W-1:0] divider;
      logic [BUS_W-1:0] bus_clk;
   } d2_side_type;

   // AHB prescaler as a right shift: divide 2,4,8,16,64,128,256,512
   function automatic logic [SHIFT_W-1:0] ahb_shift(input logic [3:0] code);
      logic [SHIFT_W-1:0] sh;
      case (code)
         4'd8:    sh = 4'd1;
         4'd9:    sh = 4'd2;
         4'd10:   sh = 4'd3;
         4'd11:   sh = 4'd4;
         4'd12:   sh = 4'd6;
         4'd13:   sh = 4'd7;
         4'd14:   sh = 4'd8;
         4'd15:   sh = 4'd9;
         default: sh = 4'd0;
      endcase
      return sh;
   endfunction

   // APB prescaler as a right shift: divide 2,4,8,16
   function automatic logic [2:0] apb_shift(input logic [2:0] code);
      logic [2:0] sh;
      case (code)
         3'd4:    sh = 3'd1;
         3'd5:    sh = 3'd2;
         3'd6:    sh = 3'd3;
         3'd7:    sh = 3'd4;
         default: sh = 3'd0;
      endcase
      return sh;
   endfunction

endpackage

// ===== sv/ubd_csr.sv =====
// Clock-tree setting registers of the UART baud divider.
// Depends on ubd_pkg for the register index codes and cfg_type.
module ubd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ubd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ubd_pkg::CSR_DATA_W-1:0]     csr_data,
   output ubd_pkg::cfg_type                   cfg_o
);

   ubd_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg_o     = cfg_ff;

   // Write one register per item; unknown indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            ubd_pkg::CSR_SYSCLK_SOURCE:     cfg_ff.sysclk_source          <= csr_data[1:0];
            ubd_pkg::CSR_PLL_MULT_CODE:     cfg_ff.pll_mult_code          <= csr_data[3:0];
            ubd_pkg::CSR_PLL_FROM_EXTERNAL: cfg_ff.pll_from_external      <= csr_data[0];
            ubd_pkg::CSR_EXTERNAL_HALVED:   cfg_ff.external_halved        <= csr_data[0];
            ubd_pkg::CSR_AHB_PRESCALE:      cfg_ff.ahb_prescale_code      <= csr_data[3:0];
            ubd_pkg::CSR_SLOW_PRESCALE:     cfg_ff.slow_bus_prescale_code <= csr_data[2:0];
            ubd_pkg::CSR_FAST_PRESCALE:     cfg_ff.fast_bus_prescale_code <= csr_data[2:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== sv/ubd_clock.sv =====
// Two pipeline stages that work out the bus clock of the requested port.
// Depends on ubd_pkg for widths, clock source codes and prescaler tables.
module ubd_clock #(
   parameter int INTERNAL_OSC_HZ = ubd_pkg::INTERNAL_OSC_HZ_DEF,
   parameter int EXTERNAL_OSC_HZ = ubd_pkg::EXTERNAL_OSC_HZ_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en_i,
   input  ubd_pkg::cfg_type                  cfg_i,
   input  logic                              valid_i,
   input  logic [ubd_pkg::PORT_W-1:0]        port_i,
   input  logic [ubd_pkg::BAUD_W-1:0]        baud_i,
   output logic                              valid_o,
   output logic                              bad_port_o,
   output logic [ubd_pkg::BAUD_W-1:0]        baud_o,
   output logic [ubd_pkg::CLK_W-1:0]         bus_clk_o
);

   localparam int CW = ubd_pkg::CLK_W;
   localparam logic [CW-1:0] INT_HZ      = CW'(INTERNAL_OSC_HZ);
   localparam logic [CW-1:0] EXT_HZ      = CW'(EXTERNAL_OSC_HZ);
   localparam logic [CW-1:0] INT_HALF_HZ = CW'(INTERNAL_OSC_HZ / 2);
   localparam logic [CW-1:0] EXT_HALF_HZ = CW'(EXTERNAL_OSC_HZ / 2);

   logic [ubd_pkg::MULT_W-1:0]  pll_mult;
   logic [CW-1:0]               pll_in;
   logic [CW-1:0]               sys_in;
   logic [ubd_pkg::SHIFT_W-1:0] shift_in;
   logic [2:0]                  apb_code;

   // Stage A registers
   logic                        va_ff;
   logic                        bad_a_ff;
   logic [ubd_pkg::BAUD_W-1:0]  baud_a_ff;
   logic [CW-1:0]               sys_ff;
   logic [ubd_pkg::SHIFT_W-1:0] shift_ff;

   // Stage B registers
   logic                        vb_ff;
   logic                        bad_b_ff;
   logic [ubd_pkg::BAUD_W-1:0]  baud_b_ff;
   logic [CW-1:0]               bus_ff;
   logic [CW-1:0]               bus_in;

   // PLL factor is code plus two, capped at sixteen
   assign pll_mult = (cfg_i.pll_mult_code >= ubd_pkg::PLL_CAP_CODE) ? ubd_pkg::PLL_MULT_MAX
                   : ubd_pkg::MULT_W'(cfg_i.pll_mult_code) + ubd_pkg::PLL_MULT_BASE;

   // PLL input: external, optionally halved, or internal halved
   always_comb begin
      if (cfg_i.pll_from_external) begin
         pll_in = cfg_i.external_halved ? EXT_HALF_HZ : EXT_HZ;
      end else begin
         pll_in = INT_HALF_HZ;
      end
   end

   // Select the system clock
   always_comb begin
      case (ubd_pkg::src_type'(cfg_i.sysclk_source))
         ubd_pkg::SRC_EXTERNAL: sys_in = EXT_HZ;
         ubd_pkg::SRC_PLL:      sys_in = pll_in * CW'(pll_mult);
         default:               sys_in = INT_HZ;
      endcase
   end

   // Total prescale as one shift: AHB then the port's APB
   assign apb_code = (port_i == ubd_pkg::PORT_FAST) ? cfg_i.fast_bus_prescale_code
                   : cfg_i.slow_bus_prescale_code;
   assign shift_in = ubd_pkg::ahb_shift(cfg_i.ahb_prescale_code)
                   + ubd_pkg::SHIFT_W'(ubd_pkg::apb_shift(apb_code));

   assign bus_in = sys_ff >> shift_ff;

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en_i) begin
         va_ff <= valid_i;
         vb_ff <= va_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en_i) begin
         bad_a_ff  <= (port_i == ubd_pkg::PORT_INVALID);
         baud_a_ff <= baud_i;
         sys_ff    <= sys_in;
         shift_ff  <= shift_in;
         bad_b_ff  <= bad_a_ff;
         baud_b_ff <= baud_a_ff;
         bus_ff    <= bus_in;
      end
   end

   assign valid_o    = vb_ff;
   assign bad_port_o = bad_b_ff;
   assign baud_o     = baud_b_ff;
   assign bus_clk_o  = bus_ff;

endmodule

// ===== sv/ubd_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on assert_macros.svh; the quotient must fit in QUO_W bits.
`include "assert_macros.svh"

module ubd_div_pipe #(
   parameter int NUM_W  = 33,
   parameter int DEN_W  = 32,
   parameter int QUO_W  = 16,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en_i,
   input  logic              valid_i,
   input  logic [NUM_W-1:0]  num_i,
   input  logic [DEN_W-1:0]  den_i,
   input  logic [SIDE_W-1:0] side_i,
   output logic              valid_o,
   output logic [QUO_W-1:0]  quo_o,
   output logic [SIDE_W-1:0] side_o
);

   localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [QUO_W-1:0]  vld_ff;
   logic [NUM_W-1:0]  rem_ff  [QUO_W];
   logic [DEN_W-1:0]  den_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int BIT = QUO_W - 1 - k;

      logic              vld_src;
      logic [NUM_W-1:0]  rem_src;
      logic [DEN_W-1:0]  den_src;
      logic [QUO_W-1:0]  quo_src;
      logic [SIDE_W-1:0] side_src;
      logic [CMP_W-1:0]  rem_wide;
      logic [CMP_W-1:0]  den_shift;
      logic              take;
      logic [NUM_W-1:0]  rem_in;
      logic [QUO_W-1:0]  quo_in;

      if (k == 0) begin : g_first
         assign vld_src  = valid_i;
         assign rem_src  = num_i;
         assign den_src  = den_i;
         assign quo_src  = '0;
         assign side_src = side_i;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign quo_src  = quo_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      // Trial subtract of the shifted divisor
      assign rem_wide  = CMP_W'(rem_src);
      assign den_shift = CMP_W'(den_src) << BIT;
      assign take      = (rem_wide >= den_shift);
      assign rem_in    = take ? NUM_W'(rem_wide - den_shift) : rem_src;
      assign quo_in    = take ? (quo_src | (QUO_W'(1) << BIT)) : quo_src;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en_i) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en_i) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_src;
            quo_ff[k]  <= quo_in;
            side_ff[k] <= side_src;
         end
      end
   end

   assign valid_o = vld_ff[QUO_W-1];
   assign quo_o   = quo_ff[QUO_W-1];
   assign side_o  = side_ff[QUO_W-1];

   // A stalled pipeline holds its last stage
   `ASSERT_NEXT(a_div_stall_holds, !en_i, $stable(valid_o) && $stable(quo_o), "divider moved while stalled")

endmodule

// ===== sv/uart_baud_divider_from_clock_tree.sv =====
// UART baud divider from the clock-tree settings: top level.
// Depends on ubd_pkg, ubd_csr, ubd_clock, ubd_div_pipe and assert_macros.svh.
//
// Usage:
//   csr_*  : write channel for the clock-tree settings, always ready; write
//            only while no request is in flight.
//   req_*  : one request per item, port and requested baud rate.
//   rsp_*  : one result per request, in request order: status, rounded
//            divider, actual baud rate and the port's bus clock.
// Throughput: one item per cycle while not stalled. Pipeline: the item passes
//   44 registers, the first loaded at the accepting edge: 2 clock-tree
//   stages, 1 rounding stage, 16 stages of the baud division (one quotient
//   bit each), 24 stages of the actual-baud division and the output
//   register.
// Reset: synchronous; clears all settings to zero and empties the pipeline.
// Stall: while a result waits in the output register and rsp_tready is low,
//   the whole pipeline holds and req_tready is low; nothing is lost or
//   repeated, and the pipeline moves again in the cycle rsp_tready rises.
`include "assert_macros.svh"

module uart_baud_divider_from_clock_tree #(
   parameter int INTERNAL_OSC_HZ = ubd_pkg::INTERNAL_OSC_HZ_DEF,
   parameter int EXTERNAL_OSC_HZ = ubd_pkg::EXTERNAL_OSC_HZ_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Setting writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ubd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ubd_pkg::CSR_DATA_W-1:0]      csr_data,
   // Requests
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ubd_pkg::REQ_TDATA_W-1:0]     req_tdata,  // port[1:0], baud_req[33:2]
   // Results
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ubd_pkg::RSP_TDATA_W-1:0]     rsp_tdata   // status[1:0], divider[17:2],
                                                           // achieved_baud[40:18],
                                                           // bus_clock_hz[67:41]
);

   localparam int D1_SIDE_W = $bits(ubd_pkg::d1_side_type);
   localparam int D2_SIDE_W = $bits(ubd_pkg::d2_side_type);
   localparam int RSP_PAD_W = ubd_pkg::RSP_TDATA_W - 2 - ubd_pkg::DIV_W
                            - ubd_pkg::ACTUAL_W - ubd_pkg::BUS_W;

   ubd_pkg::cfg_type cfg;
   logic             adv;

   // Clock-tree stages
   logic                        clk_valid;
   logic                        clk_bad;
   logic [ubd_pkg::BAUD_W-1:0]  clk_baud;
   logic [ubd_pkg::CLK_W-1:0]   clk_bus;

   // Rounding stage
   logic                        vc_ff;
   logic                        bad_c_ff;
   logic                        zero_c_ff;
   logic [ubd_pkg::BAUD_W-1:0]  baud_c_ff;
   logic [ubd_pkg::CLK_W-1:0]   bus_c_ff;
   logic [ubd_pkg::NUM_W-1:0]   num_c_ff;
   logic [ubd_pkg::NUM_W-1:0]   num_in;
   logic                        too_slow;
   ubd_pkg::d1_side_type        d1_side_in;

   // Baud division
   logic                        d1_valid;
   logic [ubd_pkg::DIV_W-1:0]   d1_quo;
   logic [D1_SIDE_W-1:0]        d1_side_vec;
   ubd_pkg::d1_side_type        d1_side;
   ubd_pkg::d2_side_type        d2_side_in;

   // Actual-baud division
   logic                        d2_valid;
   logic [ubd_pkg::Q2_W-1:0]    d2_quo;
   logic [D2_SIDE_W-1:0]        d2_side_vec;
   ubd_pkg::d2_side_type        d2_side;

   // Output register
   logic                         rsp_valid_ff;
   ubd_pkg::status_type          status_ff;
   logic [ubd_pkg::DIV_W-1:0]    divider_ff;
   logic [ubd_pkg::ACTUAL_W-1:0] actual_ff;
   logic [ubd_pkg::BUS_W-1:0]    bus_ff;

   // The whole pipeline moves unless a result waits untaken
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   ubd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg_o     (cfg)
   );

   ubd_clock #(
      .INTERNAL_OSC_HZ (INTERNAL_OSC_HZ),
      .EXTERNAL_OSC_HZ (EXTERNAL_OSC_HZ)
   ) u_clock (
      .clock      (clock),
      .reset      (reset),
      .en_i       (adv),
      .cfg_i      (cfg),
      .valid_i    (req_tvalid),
      .port_i     (req_tdata[1:0]),
      .baud_i     (req_tdata[33:2]),
      .valid_o    (clk_valid),
      .bad_port_o (clk_bad),
      .baud_o     (clk_baud),
      .bus_clk_o  (clk_bus)
   );

   // Add half the baud rate for rounding
   assign num_in = ubd_pkg::NUM_W'(clk_bus) + ubd_pkg::NUM_W'(clk_baud >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (adv) begin
         vc_ff <= clk_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bad_c_ff  <= clk_bad;
         zero_c_ff <= (clk_baud == '0);
         baud_c_ff <= clk_baud;
         bus_c_ff  <= clk_bus;
         num_c_ff  <= num_in;
      end
   end

   // Quotient of 65536 or more exactly when num / 65536 reaches the baud rate
   assign too_slow = (ubd_pkg::BAUD_W'(num_c_ff[ubd_pkg::NUM_W-1:ubd_pkg::DIV_W]) >= baud_c_ff);

   assign d1_side_in.bad_port  = bad_c_ff;
   assign d1_side_in.zero_baud = zero_c_ff;
   assign d1_side_in.too_slow  = too_slow;
   assign d1_side_in.bus_clk   = bus_c_ff;

   ubd_div_pipe #(
      .NUM_W  (ubd_pkg::NUM_W),
      .DEN_W  (ubd_pkg::BAUD_W),
      .QUO_W  (ubd_pkg::DIV_W),
      .SIDE_W (D1_SIDE_W)
   ) u_div_baud (
      .clock   (clock),
      .reset   (reset),
      .en_i    (adv),
      .valid_i (vc_ff),
      .num_i   (num_c_ff),
      .den_i   (baud_c_ff),
      .side_i  (d1_side_in),
      .valid_o (d1_valid),
      .quo_o   (d1_quo),
      .side_o  (d1_side_vec)
   );

   assign d1_side = ubd_pkg::d1_side_type'(d1_side_vec);

   // Classify the request and drop the fields a failed one does not report
   always_comb begin
      if (d1_side.bad_port || d1_side.zero_baud) begin
         d2_side_in.status = ubd_pkg::ST_BAD_REQ;
      end else if (d1_side.too_slow || (d1_quo < ubd_pkg::DIV_MIN)) begin
         d2_side_in.status = ubd_pkg::ST_RANGE;
      end else begin
         d2_side_in.status = ubd_pkg::ST_OK;
      end
      d2_side_in.divider = (d2_side_in.status == ubd_pkg::ST_OK) ? d1_quo : '0;
      d2_side_in.bus_clk = d1_side.bad_port ? '0 : d1_side.bus_clk[ubd_pkg::BUS_W-1:0];
   end

   ubd_div_pipe #(
      .NUM_W  (ubd_pkg::CLK_W),
      .DEN_W  (ubd_pkg::DIV_W),
      .QUO_W  (ubd_pkg::Q2_W),
      .SIDE_W (D2_SIDE_W)
   ) u_div_actual (
      .clock   (clock),
      .reset   (reset),
      .en_i    (adv),
      .valid_i (d1_valid),
      .num_i   (d1_side.bus_clk),
      .den_i   (d1_quo),
      .side_i  (d2_side_in),
      .valid_o (d2_valid),
      .quo_o   (d2_quo),
      .side_o  (d2_side_vec)
   );

   assign d2_side = ubd_pkg::d2_side_type'(d2_side_vec);

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         status_ff  <= d2_side.status;
         divider_ff <= d2_side.divider;
         actual_ff  <= (d2_side.status == ubd_pkg::ST_OK) ? d2_quo[ubd_pkg::ACTUAL_W-1:0] : '0;
         bus_ff     <= d2_side.bus_clk;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), bus_ff, actual_ff, divider_ff, status_ff};

   // Pipeline checks
   `ASSERT_SAME(a_stall_blocks_input, rsp_valid_ff && !rsp_tready, !req_tready, "input taken while output stalled")
   `ASSERT_SAME(a_ok_divider_in_range, rsp_valid_ff && (status_ff == ubd_pkg::ST_OK), divider_ff >= ubd_pkg::DIV_MIN, "ok result with divider below minimum")
   `ASSERT_SAME(a_fail_fields_zero, rsp_valid_ff && (status_ff != ubd_pkg::ST_OK), (divider_ff == '0) && (actual_ff == '0), "failed result carries a divider")

endmodule
